FILE: rtl/expression_language_lexer_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the expression language lexer
// ---------------------------------------------------------------------------
`ifndef EXPRESSION_LANGUAGE_LEXER_ASSERT_SVH
`define EXPRESSION_LANGUAGE_LEXER_ASSERT_SVH

// Checked property, masked while reset is high
`define ELL_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property that also holds during reset
`define ELL_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ell_pkg.sv
// ---------------------------------------------------------------------------
// ell_pkg
// Shared types, token codes, character constants and classifiers for the
// expression language lexer.
// ---------------------------------------------------------------------------
package ell_pkg;

   // Field widths
   localparam int LINE_BITS   = 16;
   localparam int OFFSET_BITS = 24;
   localparam int LENGTH_BITS = 16;
   localparam int KIND_BITS   = 5;
   localparam int WINDOW_BITS = 40;

   // Result queue sizing
   localparam int MAX_RESULTS   = 3;
   localparam int BATCH_BITS    = $clog2(MAX_RESULTS + 1);
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;
   localparam int ACCEPT_LEVEL  = FIFO_DEPTH - MAX_RESULTS;

   // Token kinds
   localparam logic [KIND_BITS-1:0] KIND_INT     = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_FLOAT   = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_LET     = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_PRINT   = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_KW_INT  = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_KW_FLT  = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_VEC     = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_EQUAL   = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_COLON   = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_UNKNOWN = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_END     = 5'd20;

   // Characters
   localparam logic [7:0] CHAR_SLASH      = 8'h2F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DOT        = 8'h2E;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0A;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;
   localparam logic [7:0] CHAR_TAB        = 8'h09;
   localparam logic [7:0] CHAR_CR         = 8'h0D;

   // Keywords, right aligned in the byte window
   localparam logic [WINDOW_BITS-1:0] KW_LET   = 40'h00_006C_6574;
   localparam logic [WINDOW_BITS-1:0] KW_INT   = 40'h00_0069_6E74;
   localparam logic [WINDOW_BITS-1:0] KW_VEC   = 40'h00_0076_6563;
   localparam logic [WINDOW_BITS-1:0] KW_PRINT = 40'h70_7269_6E74;
   localparam logic [WINDOW_BITS-1:0] KW_FLOAT = 40'h66_6C6F_6174;

   // Request and response payloads
   typedef struct packed {
      logic [7:0] source_byte;
      logic       byte_valid;
      logic       end_of_source;
   } req_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   token_kind;
      logic [LINE_BITS-1:0]   start_line;
      logic [LINE_BITS-1:0]   start_column;
      logic [OFFSET_BITS-1:0] start_offset;
      logic [LENGTH_BITS-1:0] token_length;
      logic [7:0]             token_byte;
      logic                   last_of_run;
   } rsp_type;

   // Tokens produced by one request, slot 0 first
   typedef struct packed {
      logic [BATCH_BITS-1:0]        count;
      rsp_type [MAX_RESULTS-1:0]    tok;
   } tok_batch_type;

   function automatic logic digit_char(logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic letter_char(logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A)) ||
             (b == CHAR_UNDERSCORE);
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

   // Single-character operator, or unknown
   function automatic logic [KIND_BITS-1:0] op_kind(logic [7:0] b);
      logic [KIND_BITS-1:0] k;
      unique case (b)
         8'h2B:   k = KIND_PLUS;
         8'h2D:   k = KIND_MINUS;
         8'h2A:   k = KIND_STAR;
         8'h2F:   k = KIND_SLASH;
         8'h3D:   k = KIND_EQUAL;
         8'h3A:   k = KIND_COLON;
         8'h2C:   k = KIND_COMMA;
         8'h28:   k = KIND_LPAREN;
         8'h29:   k = KIND_RPAREN;
         8'h5B:   k = KIND_LBRACK;
         8'h5D:   k = KIND_RBRACK;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // Keyword match on the last five identifier bytes and the length
   function automatic logic [KIND_BITS-1:0] ident_kind(logic [WINDOW_BITS-1:0] w,
                                                      logic [LENGTH_BITS-1:0] len);
      logic [KIND_BITS-1:0] k;
      k = KIND_IDENT;
      if (len == LENGTH_BITS'(3)) begin
         if (w == KW_LET)      k = KIND_LET;
         else if (w == KW_INT) k = KIND_KW_INT;
         else if (w == KW_VEC) k = KIND_VEC;
      end else if (len == LENGTH_BITS'(5)) begin
         if (w == KW_PRINT)      k = KIND_PRINT;
         else if (w == KW_FLOAT) k = KIND_KW_FLT;
      end
      return k;
   endfunction

endpackage

FILE: rtl/ell_core.sv
// ---------------------------------------------------------------------------
// ell_core
// Scanner state and the single-pass token logic: one request in, up to
// three tokens out, all decided in the cycle the request is taken.
// ---------------------------------------------------------------------------
module ell_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  ell_pkg::req_type      req_data,
   output ell_pkg::tok_batch_type batch
);

   localparam logic [2:0] MODE_IDLE    = 3'd0;
   localparam logic [2:0] MODE_INT     = 3'd1;
   localparam logic [2:0] MODE_FLOAT   = 3'd2;
   localparam logic [2:0] MODE_IDENT   = 3'd3;
   localparam logic [2:0] MODE_COMMENT = 3'd4;

   localparam logic [ell_pkg::LINE_BITS-1:0]   LINE_ONE = 1;
   localparam logic [ell_pkg::OFFSET_BITS-1:0] OFF_ONE  = 1;
   localparam logic [ell_pkg::LENGTH_BITS-1:0] LEN_ONE  = 1;

   logic [2:0]                      mode_ff,  mode_in;
   logic                            slash_ff, slash_in;
   logic [ell_pkg::LINE_BITS-1:0]   tline_ff, tline_in;
   logic [ell_pkg::LINE_BITS-1:0]   tcol_ff,  tcol_in;
   logic [ell_pkg::OFFSET_BITS-1:0] toff_ff,  toff_in;
   logic [ell_pkg::LENGTH_BITS-1:0] tlen_ff,  tlen_in;
   logic [ell_pkg::WINDOW_BITS-1:0] win_ff,   win_in;
   logic [7:0]                      first_ff, first_in;
   logic [ell_pkg::LINE_BITS-1:0]   line_ff,  line_in;
   logic [ell_pkg::LINE_BITS-1:0]   col_ff,   col_in;
   logic [ell_pkg::OFFSET_BITS-1:0] pos_ff,   pos_in;

   logic [7:0]                      b;
   logic                            done;
   logic [ell_pkg::BATCH_BITS-1:0]  n;
   logic [ell_pkg::LENGTH_BITS-1:0] len_ext;
   logic [ell_pkg::WINDOW_BITS-1:0] win_ext;

   function automatic ell_pkg::rsp_type make_token(
      logic [ell_pkg::KIND_BITS-1:0]   kind,
      logic [ell_pkg::LINE_BITS-1:0]   line,
      logic [ell_pkg::LINE_BITS-1:0]   col,
      logic [ell_pkg::OFFSET_BITS-1:0] off,
      logic [ell_pkg::LENGTH_BITS-1:0] len,
      logic [7:0]                      byt);
      ell_pkg::rsp_type t;
      t.token_kind   = kind;
      t.start_line   = line;
      t.start_column = col;
      t.start_offset = off;
      t.token_length = len;
      t.token_byte   = byt;
      t.last_of_run  = 1'b0;
      return t;
   endfunction

   // Kind of the open token at flush time
   function automatic logic [ell_pkg::KIND_BITS-1:0] open_kind(
      logic [2:0]                      mode,
      logic [ell_pkg::WINDOW_BITS-1:0] win,
      logic [ell_pkg::LENGTH_BITS-1:0] len);
      logic [ell_pkg::KIND_BITS-1:0] k;
      case (mode)
         MODE_INT:   k = ell_pkg::KIND_INT;
         MODE_FLOAT: k = ell_pkg::KIND_FLOAT;
         default:    k = ell_pkg::ident_kind(win, len);
      endcase
      return k;
   endfunction

   // Extension of the open token by the current byte
   assign b       = req_data.source_byte;
   assign len_ext = (tlen_ff == '1) ? tlen_ff : tlen_ff + LEN_ONE;
   assign win_ext = {win_ff[ell_pkg::WINDOW_BITS-9:0], b};

   // Token logic for one request
   always_comb begin
      mode_in  = mode_ff;
      slash_in = slash_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      toff_in  = toff_ff;
      tlen_in  = tlen_ff;
      win_in   = win_ff;
      first_in = first_ff;
      line_in  = line_ff;
      col_in   = col_ff;
      pos_in   = pos_ff;
      batch    = '0;
      n        = '0;
      done     = 1'b0;

      if (accept && req_data.byte_valid) begin
         // comment body and held slash
         if (mode_in == MODE_COMMENT) begin
            if (b == ell_pkg::CHAR_NEWLINE) mode_in = MODE_IDLE;
            done = 1'b1;
         end else if (slash_in) begin
            slash_in = 1'b0;
            if (b == ell_pkg::CHAR_SLASH) begin
               mode_in = MODE_COMMENT;
               done    = 1'b1;
            end else begin
               batch.tok[n] = make_token(ell_pkg::KIND_SLASH, tline_in, tcol_in, toff_in,
                                         LEN_ONE, ell_pkg::CHAR_SLASH);
               n = n + 1'b1;
            end
         end

         // extend the open token
         if (!done) begin
            unique case (mode_in)
               MODE_INT: begin
                  if (ell_pkg::digit_char(b)) begin
                     done = 1'b1;
                  end else if (b == ell_pkg::CHAR_DOT) begin
                     done    = 1'b1;
                     mode_in = MODE_FLOAT;
                  end
               end
               MODE_FLOAT: done = ell_pkg::digit_char(b);
               MODE_IDENT: done = ell_pkg::digit_char(b) || ell_pkg::letter_char(b);
               default: ;
            endcase
            if (done) begin
               tlen_in = len_ext;
               win_in  = win_ext;
            end else if ((mode_in == MODE_INT) || (mode_in == MODE_FLOAT) ||
                         (mode_in == MODE_IDENT)) begin
               batch.tok[n] = make_token(open_kind(mode_in, win_in, tlen_in), tline_in,
                                         tcol_in, toff_in, tlen_in, first_in);
               n       = n + 1'b1;
               mode_in = MODE_IDLE;
            end
         end

         // start a token or emit a single-byte one
         if (!done && !ell_pkg::is_space(b)) begin
            if (ell_pkg::digit_char(b) || ell_pkg::letter_char(b) ||
                (b == ell_pkg::CHAR_SLASH)) begin
               tline_in = line_ff;
               tcol_in  = col_ff;
               toff_in  = pos_ff;
               tlen_in  = LEN_ONE;
               first_in = b;
               win_in   = {{(ell_pkg::WINDOW_BITS-8){1'b0}}, b};
               if (ell_pkg::digit_char(b))       mode_in  = MODE_INT;
               else if (ell_pkg::letter_char(b)) mode_in  = MODE_IDENT;
               else                              slash_in = 1'b1;
            end else begin
               batch.tok[n] = make_token(ell_pkg::op_kind(b), line_ff, col_ff, pos_ff,
                                         LEN_ONE, b);
               n = n + 1'b1;
            end
         end

         // position counters, saturating
         if (b == ell_pkg::CHAR_NEWLINE) begin
            line_in = (line_ff == '1) ? line_ff : line_ff + LINE_ONE;
            col_in  = LINE_ONE;
         end else begin
            col_in  = (col_ff == '1) ? col_ff : col_ff + LINE_ONE;
         end
         pos_in = (pos_ff == '1) ? pos_ff : pos_ff + OFF_ONE;
      end

      // end of source: flush, then end token, then back to reset state
      if (accept && req_data.end_of_source) begin
         if ((mode_in == MODE_INT) || (mode_in == MODE_FLOAT) || (mode_in == MODE_IDENT))
         begin
            batch.tok[n] = make_token(open_kind(mode_in, win_in, tlen_in), tline_in,
                                      tcol_in, toff_in, tlen_in, first_in);
            n = n + 1'b1;
         end
         if (slash_in) begin
            batch.tok[n] = make_token(ell_pkg::KIND_SLASH, tline_in, tcol_in, toff_in,
                                      LEN_ONE, ell_pkg::CHAR_SLASH);
            n = n + 1'b1;
         end
         batch.tok[n] = make_token(ell_pkg::KIND_END, line_in, col_in, pos_in, '0, '0);
         n = n + 1'b1;

         mode_in  = MODE_IDLE;
         slash_in = 1'b0;
         tline_in = LINE_ONE;
         tcol_in  = LINE_ONE;
         toff_in  = '0;
         tlen_in  = '0;
         win_in   = '0;
         first_in = '0;
         line_in  = LINE_ONE;
         col_in   = LINE_ONE;
         pos_in   = '0;
      end

      // mark the last token of this request
      if (n != '0) batch.tok[n - 1'b1].last_of_run = 1'b1;
      batch.count = n;
   end

   // Scanner state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         slash_ff <= 1'b0;
         tline_ff <= LINE_ONE;
         tcol_ff  <= LINE_ONE;
         toff_ff  <= '0;
         tlen_ff  <= '0;
         win_ff   <= '0;
         first_ff <= '0;
         line_ff  <= LINE_ONE;
         col_ff   <= LINE_ONE;
         pos_ff   <= '0;
      end else begin
         mode_ff  <= mode_in;
         slash_ff <= slash_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         toff_ff  <= toff_in;
         tlen_ff  <= tlen_in;
         win_ff   <= win_in;
         first_ff <= first_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         pos_ff   <= pos_in;
      end
   end

endmodule

FILE: rtl/ell_fifo.sv
// ---------------------------------------------------------------------------
// ell_fifo
// Token queue: takes up to three a cycle, hands out one a cycle on rsp_ready.
// ---------------------------------------------------------------------------
module ell_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  ell_pkg::tok_batch_type push,
   output logic                   space_ok,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ell_pkg::rsp_type       rsp_data
);

   localparam int PTR = ell_pkg::FIFO_PTR_BITS;
   localparam int CNT = ell_pkg::FIFO_CNT_BITS;

   ell_pkg::rsp_type mem [ell_pkg::FIFO_DEPTH];

   logic [PTR-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT-1:0] count_ff,  count_in;
   logic           pop;

   // Handshake and occupancy
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = mem[rd_ptr_ff];
   assign space_ok  = (count_ff <= CNT'(ell_pkg::ACCEPT_LEVEL));

   assign wr_ptr_in = wr_ptr_ff + PTR'(push.count);
   assign rd_ptr_in = rd_ptr_ff + PTR'(pop);
   assign count_in  = count_ff + CNT'(push.count) - CNT'(pop);

   // Token storage
   always_ff @(posedge clock) begin
      for (int k = 0; k < ell_pkg::MAX_RESULTS; k++) begin
         if (k < int'(push.count)) mem[wr_ptr_ff + PTR'(k)] <= push.tok[k];
      end
   end

   // Pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/expression_language_lexer.sv
// ---------------------------------------------------------------------------
// expression_language_lexer
// Streaming lexer: source bytes in, token descriptors out.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one source byte per request (byte_valid) and an optional
//   end_of_source mark; a request with only end_of_source set ends the text.
//   rsp_* carries token descriptors (kind, line, column, offset, length,
//   first byte); last_of_run flags the final token caused by a request.
// Timing:
//   A request is scanned in the cycle it is taken and its tokens (0 to 3)
//   land in an 8-entry registered token queue that drives rsp_*.
//   A request is taken every cycle while the queue holds 5 or fewer
//   tokens, so text runs at one byte per cycle as long as the receiver
//   drains one token per cycle. The queue's single read port sets the
//   output rate at one token per cycle.
// Reset and stall:
//   Reset empties the queue and sets line and column to 1, offset to 0.
//   When the receiver stalls, tokens wait in the queue and req_ready
//   drops once it cannot take another three.
//   After the end token the scanner is back in its reset state.
// ---------------------------------------------------------------------------
module expression_language_lexer (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ell_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ell_pkg::rsp_type rsp_data
);

   ell_pkg::tok_batch_type batch;
   logic                   accept;

   assign accept = req_valid && req_ready;

   // Scanner
   ell_core u_core (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .batch    (batch)
   );

   // Token queue
   ell_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (batch),
      .space_ok  (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

FILE: rtl/ell_checker.sv
// ---------------------------------------------------------------------------
// ell_checker
// Port-level checks on the lexer's request and response channels.
// ---------------------------------------------------------------------------
`include "expression_language_lexer_assert.svh"

module ell_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input ell_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ell_pkg::rsp_type rsp_data
);

   logic is_single;

   // operators and unknown bytes are one byte long
   assign is_single = (rsp_data.token_kind >= ell_pkg::KIND_PLUS) &&
                      (rsp_data.token_kind <= ell_pkg::KIND_UNKNOWN);

   // stalled request holds
   `ELL_ASSERT(a_req_hold, clock, reset, req_valid && !req_ready |=> req_valid && $stable(req_data), "request changed while stalled")

   // stalled response holds
   `ELL_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response changed while stalled")

   // queue is empty right after reset
   `ELL_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")

   // end token has zero length and closes its run
   `ELL_ASSERT(a_end_token, clock, reset, rsp_valid && (rsp_data.token_kind == ell_pkg::KIND_END) |-> (rsp_data.token_length == '0) && rsp_data.last_of_run, "bad end token")

   // single-byte tokens
   `ELL_ASSERT(a_single_len, clock, reset, rsp_valid && is_single |-> rsp_data.token_length == ell_pkg::LENGTH_BITS'(1), "single-byte token length")

endmodule

bind expression_language_lexer ell_checker u_ell_checker (.*);

FILE: bench/expression_language_lexer_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// expression_language_lexer_checker
// Watches the request and token channels of the lexer, predicts the tokens
// that each accepted request must produce, and compares every token that
// leaves the block, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module expression_language_lexer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ell_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ell_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               tokens_pending,
   output int               tokens_checked
);
   import ell_pkg::*;

   localparam int PRINT_CAP = 100;
   localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
   localparam logic [OFFSET_BITS-1:0] OFF_TOP  = '1;
   localparam logic [LENGTH_BITS-1:0] LEN_TOP  = '1;

   typedef enum logic [2:0] {
      SCAN_IDLE,
      SCAN_INT,
      SCAN_FLOAT,
      SCAN_IDENT,
      SCAN_COMMENT
   } scan_state_type;

   // Scanner state of the model
   scan_state_type           scan = SCAN_IDLE;
   logic                     held_slash = 1'b0;
   logic [LINE_BITS-1:0]     tok_line = 1;
   logic [LINE_BITS-1:0]     tok_col = 1;
   logic [OFFSET_BITS-1:0]   tok_off = '0;
   logic [LENGTH_BITS-1:0]   tok_len = '0;
   logic [7:0]               tok_first = '0;
   logic [WINDOW_BITS-1:0]   kw_window = '0;
   logic [LINE_BITS-1:0]     line_no = 1;
   logic [LINE_BITS-1:0]     col_no = 1;
   logic [OFFSET_BITS-1:0]   byte_pos = '0;

   rsp_type expected_tokens[$];
   int      mismatches = 0;
   int      tokens_compared = 0;

   initial begin
      mismatch_count = 0;
      tokens_pending = 0;
      tokens_checked = 0;
   end

   function automatic logic digit_byte(logic [7:0] b);
      return (b >= "0") && (b <= "9");
   endfunction

   function automatic logic word_byte(logic [7:0] b);
      return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z")) ||
             (b == CHAR_UNDERSCORE);
   endfunction

   function automatic logic blank_byte(logic [7:0] b);
      return (b == CHAR_SPACE) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   function automatic logic [KIND_BITS-1:0] single_char_kind(logic [7:0] b);
      case (b)
         "+":     return KIND_PLUS;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "=":     return KIND_EQUAL;
         ":":     return KIND_COLON;
         ",":     return KIND_COMMA;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "[":     return KIND_LBRACK;
         "]":     return KIND_RBRACK;
         default: return KIND_UNKNOWN;
      endcase
   endfunction

   // Keywords are recognized from the last five bytes and the length
   function automatic logic [KIND_BITS-1:0] word_kind();
      if (tok_len == LENGTH_BITS'(3)) begin
         if (kw_window == {16'h0000, "let"}) return KIND_LET;
         if (kw_window == {16'h0000, "int"}) return KIND_KW_INT;
         if (kw_window == {16'h0000, "vec"}) return KIND_VEC;
      end else if (tok_len == LENGTH_BITS'(5)) begin
         if (kw_window == "print") return KIND_PRINT;
         if (kw_window == "float") return KIND_KW_FLT;
      end
      return KIND_IDENT;
   endfunction

   function automatic void clear_scanner();
      scan       = SCAN_IDLE;
      held_slash = 1'b0;
      tok_line   = 1;
      tok_col    = 1;
      tok_off    = '0;
      tok_len    = '0;
      tok_first  = '0;
      kw_window  = '0;
      line_no    = 1;
      col_no     = 1;
      byte_pos   = '0;
   endfunction

   function automatic void add_token(logic [KIND_BITS-1:0] k, logic [LINE_BITS-1:0] ln,
                                     logic [LINE_BITS-1:0] cl, logic [OFFSET_BITS-1:0] off,
                                     logic [LENGTH_BITS-1:0] len, logic [7:0] fb);
      rsp_type t;
      t.token_kind   = k;
      t.start_line   = ln;
      t.start_column = cl;
      t.start_offset = off;
      t.token_length = len;
      t.token_byte   = fb;
      t.last_of_run  = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
   endfunction

   function automatic void open_token(logic [7:0] b);
      tok_line  = line_no;
      tok_col   = col_no;
      tok_off   = byte_pos;
      tok_len   = 1;
      tok_first = b;
      kw_window = WINDOW_BITS'(b);
   endfunction

   function automatic void grow_token(logic [7:0] b);
      if (tok_len != LEN_TOP) tok_len = tok_len + 1'b1;
      kw_window = {kw_window[WINDOW_BITS-9:0], b};
   endfunction

   // Emit whatever token is open, then a slash still being held
   function automatic void close_token();
      case (scan)
         SCAN_INT:   add_token(KIND_INT, tok_line, tok_col, tok_off, tok_len, tok_first);
         SCAN_FLOAT: add_token(KIND_FLOAT, tok_line, tok_col, tok_off, tok_len, tok_first);
         SCAN_IDENT: add_token(word_kind(), tok_line, tok_col, tok_off, tok_len, tok_first);
         default: ;
      endcase
      if (scan != SCAN_COMMENT) scan = SCAN_IDLE;
      if (held_slash) begin
         add_token(KIND_SLASH, tok_line, tok_col, tok_off, 1, CHAR_SLASH);
         held_slash = 1'b0;
      end
   endfunction

   function automatic void scan_byte(logic [7:0] b);
      if (scan == SCAN_COMMENT) begin
         if (b == CHAR_NEWLINE) scan = SCAN_IDLE;
         return;
      end
      // a held slash becomes a comment or is released as an operator
      if (held_slash) begin
         held_slash = 1'b0;
         if (b == CHAR_SLASH) begin
            scan = SCAN_COMMENT;
            return;
         end
         add_token(KIND_SLASH, tok_line, tok_col, tok_off, 1, CHAR_SLASH);
      end
      // extend the open token or close it
      case (scan)
         SCAN_INT: begin
            if (digit_byte(b) || (b == CHAR_DOT)) begin
               if (b == CHAR_DOT) scan = SCAN_FLOAT;
               grow_token(b);
               return;
            end
            close_token();
         end
         SCAN_FLOAT: begin
            if (digit_byte(b)) begin
               grow_token(b);
               return;
            end
            close_token();
         end
         SCAN_IDENT: begin
            if (digit_byte(b) || word_byte(b)) begin
               grow_token(b);
               return;
            end
            close_token();
         end
         default: ;
      endcase
      // start of a new token
      if (blank_byte(b)) return;
      if (digit_byte(b)) begin
         open_token(b);
         scan = SCAN_INT;
      end else if (word_byte(b)) begin
         open_token(b);
         scan = SCAN_IDENT;
      end else if (b == CHAR_SLASH) begin
         open_token(b);
         held_slash = 1'b1;
      end else begin
         add_token(single_char_kind(b), line_no, col_no, byte_pos, 1, b);
      end
   endfunction

   function automatic void step_position(logic [7:0] b);
      if (b == CHAR_NEWLINE) begin
         if (line_no != LINE_TOP) line_no = line_no + 1'b1;
         col_no = 1;
      end else if (col_no != LINE_TOP) begin
         col_no = col_no + 1'b1;
      end
      if (byte_pos != OFF_TOP) byte_pos = byte_pos + 1'b1;
   endfunction

   // Predict the tokens of one accepted request
   function automatic void predict_request(req_type r);
      int      queued;
      rsp_type t;
      queued = expected_tokens.size();
      if (r.byte_valid) begin
         scan_byte(r.source_byte);
         step_position(r.source_byte);
      end
      if (r.end_of_source) begin
         close_token();
         add_token(KIND_END, line_no, col_no, byte_pos, '0, '0);
         clear_scanner();
      end
      if (expected_tokens.size() > queued) begin
         t = expected_tokens[expected_tokens.size() - 1];
         t.last_of_run = 1'b1;
         expected_tokens[expected_tokens.size() - 1] = t;
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < PRINT_CAP)
         $display("%0t: token %0d, %s: got 0x%0h, expected 0x%0h",
                  $time, tokens_compared, what, got, want);
      mismatches++;
   endtask

   task automatic check_token(rsp_type got);
      rsp_type want;
      if (expected_tokens.size() == 0) begin
         report_mismatch("token with none expected, kind", got.token_kind, '0);
         return;
      end
      want = expected_tokens.pop_front();
      if (got.token_kind !== want.token_kind)
         report_mismatch("token_kind", got.token_kind, want.token_kind);
      if (got.start_line !== want.start_line)
         report_mismatch("start_line", got.start_line, want.start_line);
      if (got.start_column !== want.start_column)
         report_mismatch("start_column", got.start_column, want.start_column);
      if (got.start_offset !== want.start_offset)
         report_mismatch("start_offset", got.start_offset, want.start_offset);
      if (got.token_length !== want.token_length)
         report_mismatch("token_length", got.token_length, want.token_length);
      if (got.token_byte !== want.token_byte)
         report_mismatch("token_byte", got.token_byte, want.token_byte);
      if (got.last_of_run !== want.last_of_run)
         report_mismatch("last_of_run", got.last_of_run, want.last_of_run);
      tokens_compared++;
   endtask

   // Both handshakes are sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         clear_scanner();
         expected_tokens.delete();
      end else begin
         if (req_valid && req_ready) predict_request(req_data);
         if (rsp_valid && rsp_ready) check_token(rsp_data);
      end
      mismatch_count <= mismatches;
      tokens_pending <= expected_tokens.size();
      tokens_checked <= tokens_compared;
   end

endmodule

FILE: bench/expression_language_lexer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// expression_language_lexer_test
// Drives source text into the lexer: a short directed text with every
// operator and the awkward cases, then random texts built from tokens,
// comments, whitespace and noise. Sender gaps and receiver stalls are random,
// with one long output stall that backs the block up.
// ---------------------------------------------------------------------------
module expression_language_lexer_test;
   import ell_pkg::*;

   localparam int RANDOM_ITEMS = 340;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 32;
   localparam int RUN_LIMIT    = 1_000_000;

   typedef enum logic [1:0] {
      RX_OPEN,
      RX_COIN,
      RX_THIRD,
      RX_SPARSE
   } rx_mode_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int tokens_pending;
   int tokens_checked;

   int cycle_count = 0;
   int requests_sent = 0;
   int texts_sent = 0;
   int burst_left = 0;
   int hold_requests = 0;

   logic [7:0] source_text[$];

   expression_language_lexer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   expression_language_lexer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .tokens_pending (tokens_pending),
      .tokens_checked (tokens_checked)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Receiver: stall pattern changes every window; a long hold on request
   int          holds_served = 0;
   int          hold_left = 0;
   int          window_left = 0;
   int          pattern_step = 0;
   rx_mode_type rx_mode = RX_OPEN;

   always @(posedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served <= hold_requests;
         hold_left    <= HOLD_CYCLES;
         rsp_ready    <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         if (window_left == 0) begin
            rx_mode     <= rx_mode_type'($urandom_range(0, 3));
            window_left <= $urandom_range(16, 96);
         end else begin
            window_left <= window_left - 1;
         end
         pattern_step <= (pattern_step == 2) ? 0 : pattern_step + 1;
         case (rx_mode)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_COIN:  rsp_ready <= 1'($urandom_range(0, 1));
            RX_THIRD: rsp_ready <= (pattern_step == 0);
            default:  rsp_ready <= ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   // Offer one request and wait for it to be taken; some bursts end in a gap
   task automatic send_request(input logic [7:0] b, input logic has_byte, input logic ends);
      req_type r;
      int      gap;
      r.source_byte   = b;
      r.byte_valid    = has_byte;
      r.end_of_source = ends;
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (has_byte || ends) requests_sent++;
      if (ends) texts_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 32);
         gap = 0;
         if ($urandom_range(0, 1) != 0)
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 5);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b1, 1'b0);
   endtask

   function automatic logic [7:0] letter_byte();
      int r;
      r = $urandom_range(0, 52);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      return CHAR_UNDERSCORE;
   endfunction

   function automatic logic [7:0] name_byte();
      if ($urandom_range(0, 9) < 3) return 8'("0" + $urandom_range(0, 9));
      return letter_byte();
   endfunction

   function automatic logic [7:0] blank_pick();
      case ($urandom_range(0, 5))
         0:       return CHAR_TAB;
         1:       return CHAR_NEWLINE;
         2:       return CHAR_CR;
         3:       return 8'h0B;
         4:       return 8'h0C;
         default: return CHAR_SPACE;
      endcase
   endfunction

   function automatic void add_byte(logic [7:0] b);
      source_text.insert(source_text.size(), b);
   endfunction

   function automatic void push_string(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic void push_digits(int n);
      repeat (n) add_byte(8'("0" + $urandom_range(0, 9)));
   endfunction

   // One lexeme of random text, mostly well formed
   function automatic void push_piece();
      string words;
      string ops;
      string odd;
      logic [7:0] b;
      words = "let  printint  floatvec  lets prin Int  flot ve   ";
      ops   = "+-*/=:,()[]";
      odd   = "!#$%&.;<>?@^`{|}~\\\"'";
      case ($urandom_range(0, 19))
         0, 1, 2, 3: begin
            // keywords and near misses, five columns per entry
            for (int i = 0; i < 5; i++) begin
               b = words[5 * $urandom_range(0, 9) + i];
               if (b != CHAR_SPACE) add_byte(b);
            end
         end
         4, 5, 6: begin
            add_byte(letter_byte());
            repeat ($urandom_range(0, 7)) add_byte(name_byte());
         end
         7, 8, 9: push_digits($urandom_range(1, 6));
         10, 11: begin
            push_digits($urandom_range(1, 3));
            add_byte(CHAR_DOT);
            push_digits($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0) begin
               add_byte(CHAR_DOT);
               push_digits($urandom_range(0, 2));
            end
         end
         12, 13, 14, 15: add_byte(ops[$urandom_range(0, 10)]);
         16: begin
            push_string("//");
            repeat ($urandom_range(0, 6)) begin
               b = 8'($urandom_range(0, 255));
               add_byte((b == CHAR_NEWLINE) ? CHAR_SPACE : b);
            end
            add_byte(CHAR_NEWLINE);
         end
         17: repeat ($urandom_range(1, 4)) add_byte(blank_pick());
         18: begin
            if ($urandom_range(0, 1) != 0) add_byte(odd[$urandom_range(0, 19)]);
            else add_byte(8'($urandom_range(128, 255)));
         end
         default: repeat ($urandom_range(1, 4)) add_byte(8'($urandom_range(0, 255)));
      endcase
   endfunction

   // Build one random text and send it, ending on its last byte or apart
   task automatic send_random_text();
      int pieces;
      bit end_on_byte;
      source_text.delete();
      pieces = $urandom_range(0, 14);
      repeat (pieces) begin
         push_piece();
         if ($urandom_range(0, 2) != 0) add_byte(blank_pick());
      end
      end_on_byte = (source_text.size() != 0) && ($urandom_range(0, 1) != 0);
      foreach (source_text[i]) begin
         if ($urandom_range(0, 24) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_request(source_text[i], 1'b1, end_on_byte && (i == source_text.size() - 1));
      end
      if (!end_on_byte) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
   endtask

   // Run limit
   initial begin
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int first_random;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: every operator, held slash released by a letter, second dot,
      // digits then letters, comment, byte extremes, empty request, slash at end
      send_string("+-*=:,()[]/a 1.2.7q//x\n");
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b0);
      send_request(CHAR_SLASH, 1'b1, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);

      // Random texts; the receiver holds off at the start to fill the block
      hold_requests <= hold_requests + 1;
      first_random = requests_sent;
      while (requests_sent - first_random < RANDOM_ITEMS) send_random_text();

      req_valid <= 1'b0;
      @(posedge clock);
      while (tokens_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d source texts in %0d requests; %0d tokens compared.",
               texts_sent, requests_sent, tokens_checked);
      $display("Text mixed keywords, numbers, comments and stray bytes, with a %0d-cycle stall.",
               HOLD_CYCLES);
      if ((mismatch_count == 0) && (tokens_pending == 0)) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
